// ----- src/vcs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcs_pkg
// Shared types and constants for the velocity command smoother.
// ----------------------------------------------------------------------------
package vcs_pkg;

    // Fixed field widths
    localparam int CMD_W        = 16;
    localparam int GAIN_W       = 12;
    localparam int ALPHA_W      = 9;
    localparam int MIN_W        = 15;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 15;
    localparam int COEF_W       = GAIN_W + 1;   // signed multiplier operand B
    localparam int FRAC_BITS    = 8;

    localparam int SPEED_WIDTH_DEF = 16;

    // Register reset values
    localparam logic [GAIN_W-1:0]  ANGULAR_GAIN_RST  = 12'd1280;
    localparam logic [GAIN_W-1:0]  LINEAR_GAIN_RST   = 12'd256;
    localparam logic [ALPHA_W-1:0] ANGULAR_ALPHA_RST = 9'd205;
    localparam logic [ALPHA_W-1:0] LINEAR_ALPHA_RST  = 9'd205;
    localparam logic [MIN_W-1:0]   MIN_LINEAR_RST    = 15'd38;
    localparam logic [MIN_W-1:0]   MIN_ANGULAR_RST   = 15'd26;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANGULAR_GAIN  = 3'd0,
        REG_LINEAR_GAIN   = 3'd1,
        REG_ANGULAR_ALPHA = 3'd2,
        REG_LINEAR_ALPHA  = 3'd3,
        REG_MIN_LINEAR    = 3'd4,
        REG_MIN_ANGULAR   = 3'd5
    } reg_idx_t;

    localparam logic ACT_COMMAND = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    typedef struct packed {
        logic [GAIN_W-1:0]  angular_gain;
        logic [GAIN_W-1:0]  linear_gain;
        logic [ALPHA_W-1:0] angular_alpha;
        logic [ALPHA_W-1:0] linear_alpha;
        logic [MIN_W-1:0]   lin_floor;
        logic [MIN_W-1:0]   ang_floor;
    } cfg_t;

    // Multiplier operand selection
    typedef enum logic [2:0] {
        MUL_LIN_GAIN  = 3'd0,
        MUL_ANG_GAIN  = 3'd1,
        MUL_LIN_PREV  = 3'd2,
        MUL_LIN_CUR   = 3'd3,
        MUL_ANG_PREV  = 3'd4,
        MUL_ANG_CUR   = 3'd5
    } mul_sel_t;

    typedef struct packed {
        logic     load_cmd;     // capture command word into held regs
        mul_sel_t mul_sel;
        logic     acc_load;     // acc <= product + rounding constant
        logic     lin_gain_wr;  // linear result <= round_sat(product)
        logic     ang_gain_wr;
        logic     lin_blend;    // linear result <= sat(acc + product)
        logic     ang_blend;
        logic     out_load;     // load output word
        logic     out_stop;     // output word is the stop word
    } dp_cmd_t;

    typedef struct packed {
        logic keep_alive;       // a previous output axis reaches its minimum
    } dp_stat_t;

endpackage

// ----- src/velocity_command_smoother.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_command_smoother
// Velocity command smoother: takes command words and republish ticks and
// gives one output word per command, and per tick while repeating. Forward
// speed and yaw rate are scaled by their gains and then blended with the
// last output by alpha (Q8.8 values, Q4.8 gains, Q1.8 alpha). A single
// shared 13-bit-coefficient multiplier does all products, one per cycle, so
// an item holds the block until it returns to idle: the first (unblended)
// output runs the gain products, a blended output also the blend products
// and an angular finishing step, the stop word only the write step; a tick
// that gives nothing leaves the block idle. The write step stalls while the
// previous word still waits on out_ready.
// The output register lets the next word be accepted while a result still
// waits on out_ready. Off-axis command components raise off_axis_warning.
// ----------------------------------------------------------------------------
module velocity_command_smoother
    import vcs_pkg::*;
#(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic signed [CMD_W-1:0]       cmd_linear_x,
    input  logic signed [CMD_W-1:0]       cmd_angular_z,
    input  logic signed [CMD_W-1:0]       cmd_linear_y,
    input  logic signed [CMD_W-1:0]       cmd_linear_z,
    input  logic signed [CMD_W-1:0]       cmd_angular_x,
    input  logic signed [CMD_W-1:0]       cmd_angular_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SPEED_WIDTH-1:0] out_linear_x,
    output logic signed [SPEED_WIDTH-1:0] out_angular_z,
    output logic                          is_stop,
    output logic                          off_axis_warning
);

    cfg_t     cfg;
    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    vcs_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (dp_cmd),
        .stat      (dp_stat)
    );

    vcs_dp #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_dp (
        .clk              (clk),
        .cfg              (cfg),
        .cmd              (dp_cmd),
        .stat             (dp_stat),
        .cmd_linear_x     (cmd_linear_x),
        .cmd_angular_z    (cmd_angular_z),
        .cmd_linear_y     (cmd_linear_y),
        .cmd_linear_z     (cmd_linear_z),
        .cmd_angular_x    (cmd_angular_x),
        .cmd_angular_y    (cmd_angular_y),
        .out_linear_x     (out_linear_x),
        .out_angular_z    (out_angular_z),
        .is_stop          (is_stop),
        .off_axis_warning (off_axis_warning)
    );

endmodule

// ----- src/vcs_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcs_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module vcs_regs
    import vcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ANGULAR_GAIN:  cfg_next.angular_gain  = cfg_data[GAIN_W-1:0];
                REG_LINEAR_GAIN:   cfg_next.linear_gain   = cfg_data[GAIN_W-1:0];
                REG_ANGULAR_ALPHA: cfg_next.angular_alpha = cfg_data[ALPHA_W-1:0];
                REG_LINEAR_ALPHA:  cfg_next.linear_alpha  = cfg_data[ALPHA_W-1:0];
                REG_MIN_LINEAR:    cfg_next.lin_floor     = cfg_data[MIN_W-1:0];
                REG_MIN_ANGULAR:   cfg_next.ang_floor     = cfg_data[MIN_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angular_gain  <= ANGULAR_GAIN_RST;
            cfg_reg.linear_gain   <= LINEAR_GAIN_RST;
            cfg_reg.angular_alpha <= ANGULAR_ALPHA_RST;
            cfg_reg.linear_alpha  <= LINEAR_ALPHA_RST;
            cfg_reg.lin_floor     <= MIN_LINEAR_RST;
            cfg_reg.ang_floor     <= MIN_ANGULAR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/vcs_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcs_dp
// Datapath: held command, shared multiplier, accumulator, round/saturate,
// previous outputs and the output word register.
// ----------------------------------------------------------------------------
module vcs_dp
    import vcs_pkg::*;
#(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
)
(
    input  logic                          clk,
    input  cfg_t                          cfg,
    input  dp_cmd_t                       cmd,
    output dp_stat_t                      stat,
    input  logic signed [CMD_W-1:0]       cmd_linear_x,
    input  logic signed [CMD_W-1:0]       cmd_angular_z,
    input  logic signed [CMD_W-1:0]       cmd_linear_y,
    input  logic signed [CMD_W-1:0]       cmd_linear_z,
    input  logic signed [CMD_W-1:0]       cmd_angular_x,
    input  logic signed [CMD_W-1:0]       cmd_angular_y,
    output logic signed [SPEED_WIDTH-1:0] out_linear_x,
    output logic signed [SPEED_WIDTH-1:0] out_angular_z,
    output logic                          is_stop,
    output logic                          off_axis_warning
);

    localparam int SW    = SPEED_WIDTH;
    localparam int MA    = (SW > CMD_W) ? SW : CMD_W;   // operand A width
    localparam int PW    = MA + COEF_W;                 // product width
    localparam int ACC_W = PW + 1;

    localparam logic signed [ACC_W-1:0] RND    = ACC_W'(128);
    localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-SW+1){1'b1}}, {(SW-1){1'b0}}};

    logic signed [CMD_W-1:0]  held_lin_reg;
    logic signed [CMD_W-1:0]  held_ang_reg;
    logic                     held_off_reg;
    logic signed [SW-1:0]     prev_lin_reg;
    logic signed [SW-1:0]     prev_ang_reg;
    logic signed [SW-1:0]     res_lin_reg;
    logic signed [SW-1:0]     res_ang_reg;
    logic signed [PW-1:0]     prod_reg;
    logic signed [PW-1:0]     prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [MA-1:0]     mul_a;
    logic signed [COEF_W-1:0] mul_b;

    logic [ALPHA_W-1:0] alpha_lin;
    logic [ALPHA_W-1:0] alpha_ang;
    logic [ALPHA_W-1:0] inv_lin;
    logic [ALPHA_W-1:0] inv_ang;

    logic signed [ACC_W-1:0] rnd_sum;
    logic signed [ACC_W-1:0] rnd_shift;
    logic signed [SW-1:0]    rnd_sat;

    logic                    off_axis;
    logic [MA:0]             mag_lin;
    logic [MA:0]             mag_ang;

    // Alpha above one counts as one
    assign alpha_lin = (cfg.linear_alpha  > ALPHA_ONE) ? ALPHA_ONE : cfg.linear_alpha;
    assign alpha_ang = (cfg.angular_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.angular_alpha;
    assign inv_lin   = ALPHA_ONE - alpha_lin;
    assign inv_ang   = ALPHA_ONE - alpha_ang;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_LIN_GAIN:
            begin
                mul_a = MA'(held_lin_reg);
                mul_b = $signed({1'b0, cfg.linear_gain});
            end
            MUL_ANG_GAIN:
            begin
                mul_a = MA'(held_ang_reg);
                mul_b = $signed({1'b0, cfg.angular_gain});
            end
            MUL_LIN_PREV:
            begin
                mul_a = MA'(prev_lin_reg);
                mul_b = $signed(COEF_W'(alpha_lin));
            end
            MUL_LIN_CUR:
            begin
                mul_a = MA'(res_lin_reg);
                mul_b = $signed(COEF_W'(inv_lin));
            end
            MUL_ANG_PREV:
            begin
                mul_a = MA'(prev_ang_reg);
                mul_b = $signed(COEF_W'(alpha_ang));
            end
            MUL_ANG_CUR:
            begin
                mul_a = MA'(res_ang_reg);
                mul_b = $signed(COEF_W'(inv_ang));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Round half up, drop the fraction, clamp to the speed range.
    // Accumulator already carries the rounding constant.
    assign rnd_sum   = (cmd.lin_blend || cmd.ang_blend) ? (acc_reg + ACC_W'(prod_reg))
                                                        : (ACC_W'(prod_reg) + RND);
    assign rnd_shift = rnd_sum >>> FRAC_BITS;

    always_comb
    begin
        if (rnd_shift > SAT_HI)
            rnd_sat = SAT_HI[SW-1:0];
        else if (rnd_shift < SAT_LO)
            rnd_sat = SAT_LO[SW-1:0];
        else
            rnd_sat = rnd_shift[SW-1:0];
    end

    assign off_axis = (cmd_linear_y | cmd_linear_z | cmd_angular_x | cmd_angular_y) != '0;

    assign mag_lin = prev_lin_reg[SW-1] ? -((MA+1)'(prev_lin_reg)) : (MA+1)'(prev_lin_reg);
    assign mag_ang = prev_ang_reg[SW-1] ? -((MA+1)'(prev_ang_reg)) : (MA+1)'(prev_ang_reg);

    assign stat.keep_alive = (mag_lin >= (MA+1)'(cfg.lin_floor)) ||
                             (mag_ang >= (MA+1)'(cfg.ang_floor));

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.load_cmd)
        begin
            held_lin_reg <= cmd_linear_x;
            held_ang_reg <= cmd_angular_z;
            held_off_reg <= off_axis;
        end
        if (cmd.acc_load)
            acc_reg <= ACC_W'(prod_reg) + RND;
        if (cmd.lin_gain_wr || cmd.lin_blend)
            res_lin_reg <= rnd_sat;
        if (cmd.ang_gain_wr || cmd.ang_blend)
            res_ang_reg <= rnd_sat;
        if (cmd.out_load)
        begin
            if (cmd.out_stop)
            begin
                out_linear_x     <= '0;
                out_angular_z    <= '0;
                is_stop          <= 1'b1;
                off_axis_warning <= 1'b0;
            end
            else
            begin
                out_linear_x     <= res_lin_reg;
                out_angular_z    <= res_ang_reg;
                is_stop          <= 1'b0;
                off_axis_warning <= held_off_reg;
                prev_lin_reg     <= res_lin_reg;
                prev_ang_reg     <= res_ang_reg;
            end
        end
    end

endmodule

// ----- src/vcs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcs_ctrl
// Controller: handshakes, sequence of multiplies, filter control state.
// ----------------------------------------------------------------------------
module vcs_ctrl
    import vcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     action,
    output logic     out_valid,
    input  logic     out_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_LIN_GAIN = 8'b0000_0010,
        ST_ANG_GAIN = 8'b0000_0100,
        ST_LIN_PREV = 8'b0000_1000,
        ST_LIN_CUR  = 8'b0001_0000,
        ST_ANG_PREV = 8'b0010_0000,
        ST_ANG_CUR  = 8'b0100_0000,
        ST_WRITE    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   published_reg, published_next;
    logic   repeat_reg, repeat_next;
    logic   stop_reg, stop_next;
    logic   out_valid_reg, out_valid_next;
    logic   ang_fin_reg, ang_fin_next;    // blended angular product pending

    always_comb
    begin
        state_next     = state_reg;
        published_next = published_reg;
        repeat_next    = repeat_reg;
        stop_next      = stop_reg;
        ang_fin_next   = 1'b0;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.mul_sel    = MUL_LIN_GAIN;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (action == ACT_COMMAND)
                    begin
                        cmd.load_cmd = 1'b1;
                        stop_next    = 1'b0;
                        state_next   = ST_LIN_GAIN;
                    end
                    else if (repeat_reg)
                    begin
                        if (stat.keep_alive)
                        begin
                            stop_next  = 1'b0;
                            state_next = ST_LIN_GAIN;
                        end
                        else
                        begin
                            stop_next   = 1'b1;
                            repeat_next = 1'b0;
                            state_next  = ST_WRITE;
                        end
                    end
                end
            end
            ST_LIN_GAIN:
            begin
                cmd.mul_sel = MUL_LIN_GAIN;
                state_next  = ST_ANG_GAIN;
            end
            ST_ANG_GAIN:
            begin
                cmd.mul_sel     = MUL_ANG_GAIN;
                cmd.lin_gain_wr = 1'b1;
                state_next      = ST_LIN_PREV;
            end
            ST_LIN_PREV:
            begin
                cmd.mul_sel     = MUL_LIN_PREV;
                cmd.ang_gain_wr = 1'b1;
                state_next      = published_reg ? ST_LIN_CUR : ST_WRITE;
            end
            ST_LIN_CUR:
            begin
                cmd.mul_sel  = MUL_LIN_CUR;
                cmd.acc_load = 1'b1;
                state_next   = ST_ANG_PREV;
            end
            ST_ANG_PREV:
            begin
                cmd.mul_sel   = MUL_ANG_PREV;
                cmd.lin_blend = 1'b1;
                state_next    = ST_ANG_CUR;
            end
            ST_ANG_CUR:
            begin
                cmd.mul_sel  = MUL_ANG_CUR;
                cmd.acc_load = 1'b1;
                ang_fin_next = 1'b1;
                state_next   = ST_WRITE;
            end
            ST_WRITE:
            begin
                // first WRITE cycle after blending finishes the angular axis
                if (ang_fin_reg)
                begin
                    cmd.ang_blend = 1'b1;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_stop   = stop_reg;
                    out_valid_next = 1'b1;
                    if (!stop_reg)
                    begin
                        published_next = 1'b1;
                        repeat_next    = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            published_reg <= 1'b0;
            repeat_reg    <= 1'b0;
            stop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            ang_fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            published_reg <= published_next;
            repeat_reg    <= repeat_next;
            stop_reg      <= stop_next;
            out_valid_reg <= out_valid_next;
            ang_fin_reg   <= ang_fin_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
